// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tmc_pkg.sv =====
// Shared types and codes for the transform matrix composer.
// No dependencies; used by tmc_ctrl, tmc_dpath and the top level.
package tmc_pkg;

  localparam int unsigned Dim    = 4;
  localparam int unsigned ElemW  = 32;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t [Dim-1:0] row_t;

  // Command codes
  localparam logic [2:0] CMD_LOAD       = 3'd0;
  localparam logic [2:0] CMD_IDENTITY   = 3'd1;
  localparam logic [2:0] CMD_SET_SCALE  = 3'd2;
  localparam logic [2:0] CMD_SET_TRANS  = 3'd3;
  localparam logic [2:0] CMD_COMP_SCALE = 3'd4;
  localparam logic [2:0] CMD_COMP_TRANS = 3'd5;
  localparam logic [2:0] CMD_READ       = 3'd6;

  // Whole-matrix initialization selected at command accept
  typedef enum logic [1:0] {
    INIT_IDENTITY,
    INIT_SCALE,
    INIT_TRANSLATE
  } init_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_we;    // write one element from the input word
    logic       init_en;    // rebuild the whole matrix
    init_e      init_sel;
    logic       capture;    // latch x, y, z for a compose
    logic       mul_en;     // one product for the current row
    logic [1:0] mul_col;
    logic       emit;       // write back and present the current row
    logic       compose;    // emitted row comes from the products
    logic       translate;  // compose kind: translate, else scale
    logic [1:0] row;
    logic       last;
  } dp_cmd_t;

endpackage

// ===== rtl/transform_matrix_composer.sv =====
// Top level of the 4x4 transform matrix composer.
// Depends on tmc_pkg, tmc_ctrl and tmc_dpath.
//
// Channel   Direction  Handshake               Words
// command   in         start_i / busy_o        cmd, row/col index, element, x, y, z
// result    out        result_valid_o strobe   out_row, elem_c0..c3, last_row
//
// Load writes one element and returns nothing; busy_o stays low.
// Identity, set scale, set translate and read: busy_o is high while the four rows are
// emitted; the four result words, one per cycle, are registered after each emit step.
// Scale and translate compose: per row, three multiply steps on the single shared
// 32x32 multiplier and one step for the write back and result word.
// Reset leaves the matrix at identity. Result words are strobes that the
// receiver cannot stall; the next command is taken while the last word shows.
module transform_matrix_composer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic [1:0]         row_index_i,
  input  logic [1:0]         col_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  output logic               result_valid_o,
  output logic [1:0]         out_row_o,
  output logic signed [31:0] elem_c0_o,
  output logic signed [31:0] elem_c1_o,
  output logic signed [31:0] elem_c2_o,
  output logic signed [31:0] elem_c3_o,
  output logic               last_row_o
);
  import tmc_pkg::*;

  dp_cmd_t dp_cmd;

  tmc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .dp_cmd_o (dp_cmd)
  );

  tmc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dp_cmd_i        (dp_cmd),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .result_valid_o  (result_valid_o),
    .out_row_o       (out_row_o),
    .elem_c0_o       (elem_c0_o),
    .elem_c1_o       (elem_c1_o),
    .elem_c2_o       (elem_c2_o),
    .elem_c3_o       (elem_c3_o),
    .last_row_o      (last_row_o)
  );

endmodule

// ===== rtl/tmc_ctrl.sv =====
// Command sequencer of the transform matrix composer.
// Depends on tmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        cmd_i,
  output logic              busy_o,
  output tmc_pkg::dp_cmd_t  dp_cmd_o
);
  import tmc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic       compose_q, compose_d;
  logic       trans_q, trans_d;
  logic       accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Next state and datapath commands
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    compose_d = compose_q;
    trans_d   = trans_q;
    dp_cmd_o  = '0;
    dp_cmd_o.init_sel  = INIT_IDENTITY;
    dp_cmd_o.row       = row_q;
    dp_cmd_o.mul_col   = col_q;
    dp_cmd_o.compose   = compose_q;
    dp_cmd_o.translate = trans_q;
    dp_cmd_o.last      = (row_q == 2'd3);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          row_d = '0;
          col_d = '0;
          unique case (cmd_i) inside
            CMD_LOAD: begin
              dp_cmd_o.load_we = 1'b1;
            end
            CMD_IDENTITY, CMD_SET_SCALE, CMD_SET_TRANS, CMD_READ: begin
              dp_cmd_o.init_en = (cmd_i != CMD_READ);
              if (cmd_i == CMD_SET_SCALE) begin
                dp_cmd_o.init_sel = INIT_SCALE;
              end else if (cmd_i == CMD_SET_TRANS) begin
                dp_cmd_o.init_sel = INIT_TRANSLATE;
              end
              compose_d = 1'b0;
              trans_d   = 1'b0;
              state_d   = ST_EMIT;
            end
            CMD_COMP_SCALE, CMD_COMP_TRANS: begin
              dp_cmd_o.capture = 1'b1;
              compose_d = 1'b1;
              trans_d   = (cmd_i == CMD_COMP_TRANS);
              state_d   = ST_MUL;
            end
            default: begin
              // unused code: ignored
            end
          endcase
        end
      end
      ST_MUL: begin
        dp_cmd_o.mul_en = 1'b1;
        if (col_q == 2'd2) begin
          col_d   = '0;
          state_d = ST_EMIT;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      ST_EMIT: begin
        dp_cmd_o.emit = 1'b1;
        row_d = row_q + 2'd1;
        if (row_q == 2'd3) begin
          state_d = ST_IDLE;
        end else if (compose_q) begin
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      compose_q <= 1'b0;
      trans_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      compose_q <= compose_d;
      trans_q   <= trans_d;
    end
  end

  `ASSERT_NEXT(a_last_row_ends, clk_i, rst_ni, (state_q == ST_EMIT) && (row_q == 2'd3), state_q == ST_IDLE)
  `ASSERT_IMPL(a_mul_only_compose, clk_i, rst_ni, state_q == ST_MUL, compose_q)
  `ASSERT_NEXT(a_compose_starts_mul, clk_i, rst_ni, accept && ((cmd_i == CMD_COMP_SCALE) || (cmd_i == CMD_COMP_TRANS)), (state_q == ST_MUL) && (row_q == 2'd0) && (col_q == 2'd0))

endmodule

// ===== rtl/tmc_dpath.sv =====
// Matrix store, shared multiplier and result register of the composer.
// Depends on tmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmc_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmc_pkg::dp_cmd_t    dp_cmd_i,
  input  logic [1:0]          row_index_i,
  input  logic [1:0]          col_index_i,
  input  logic signed [31:0]  element_value_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  output logic                result_valid_o,
  output logic [1:0]          out_row_o,
  output logic signed [31:0]  elem_c0_o,
  output logic signed [31:0]  elem_c1_o,
  output logic signed [31:0]  elem_c2_o,
  output logic signed [31:0]  elem_c3_o,
  output logic                last_row_o
);
  import tmc_pkg::*;

  row_t  mat_q [Dim];
  row_t  mat_d [Dim];
  elem_t cx_q, cy_q, cz_q;
  elem_t prod_q [3];
  row_t  row_rd;
  row_t  row_new;
  elem_t mul_a, mul_b, mul_res;

  row_t  res_q;
  logic  valid_q;
  logic  [1:0] res_row_q;
  logic  last_q;

  // Current row, shared by the multiplier and the write back
  assign row_rd = mat_q[dp_cmd_i.row];

  // Shared multiplier: one column of the current row per cycle
  always_comb begin
    mul_a = row_rd[dp_cmd_i.mul_col];
    case (dp_cmd_i.mul_col)
      2'd0:    mul_b = cx_q;
      2'd1:    mul_b = cy_q;
      default: mul_b = cz_q;
    endcase
  end
  assign mul_res = mul_a * mul_b;

  // Updated row for the emit step
  always_comb begin
    row_new = row_rd;
    if (dp_cmd_i.compose) begin
      if (dp_cmd_i.translate) begin
        row_new[3] = row_rd[3] + prod_q[0] + prod_q[1] + prod_q[2];
      end else begin
        row_new[0] = prod_q[0];
        row_new[1] = prod_q[1];
        row_new[2] = prod_q[2];
      end
    end
  end

  // Next matrix contents
  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      mat_d[r] = mat_q[r];
    end
    if (dp_cmd_i.load_we) begin
      mat_d[row_index_i][col_index_i] = element_value_i;
    end
    if (dp_cmd_i.init_en) begin
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          mat_d[r][c] = (r == c) ? elem_t'(1) : elem_t'(0);
        end
      end
      case (dp_cmd_i.init_sel)
        INIT_SCALE: begin
          mat_d[0][0] = coord_x_i;
          mat_d[1][1] = coord_y_i;
          mat_d[2][2] = coord_z_i;
        end
        INIT_TRANSLATE: begin
          mat_d[0][3] = coord_x_i;
          mat_d[1][3] = coord_y_i;
          mat_d[2][3] = coord_z_i;
        end
        default: begin
          // identity as built above
        end
      endcase
    end
    if (dp_cmd_i.emit && dp_cmd_i.compose) begin
      mat_d[dp_cmd_i.row] = row_new;
    end
  end

  // Matrix store, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          mat_q[r][c] <= (r == c) ? elem_t'(1) : elem_t'(0);
        end
      end
    end else begin
      for (int r = 0; r < Dim; r++) begin
        mat_q[r] <= mat_d[r];
      end
    end
  end

  // Compose operands and products
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.capture) begin
      cx_q <= coord_x_i;
      cy_q <= coord_y_i;
      cz_q <= coord_z_i;
    end
    if (dp_cmd_i.mul_en) begin
      prod_q[dp_cmd_i.mul_col] <= mul_res;
    end
  end

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dp_cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.emit) begin
      res_q     <= row_new;
      res_row_q <= dp_cmd_i.row;
      last_q    <= dp_cmd_i.last;
    end
  end

  assign result_valid_o = valid_q;
  assign out_row_o      = res_row_q;
  assign elem_c0_o      = res_q[0];
  assign elem_c1_o      = res_q[1];
  assign elem_c2_o      = res_q[2];
  assign elem_c3_o      = res_q[3];
  assign last_row_o     = last_q;

  `ASSERT_IMPL(a_last_is_row3, clk_i, rst_ni, valid_q, last_q == (res_row_q == 2'd3))
  `ASSERT_NEXT(a_gap_after_last, clk_i, rst_ni, valid_q && last_q, !valid_q)
  `ASSERT_IMPL(a_no_load_in_emit, clk_i, rst_ni, dp_cmd_i.emit, !dp_cmd_i.load_we && !dp_cmd_i.init_en)

endmodule
